/* hw/rtl/word_multiply_xor_hash_unit_macros.svh */
// Assertion macros shared by the hash unit RTL.
// Every macro expects i_clk and i_rst_n to be in scope.
`ifndef WORD_MULTIPLY_XOR_HASH_UNIT_MACROS_SVH
`define WORD_MULTIPLY_XOR_HASH_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WMXH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hash unit check failed");

// Next-cycle implication, checked outside reset.
`define WMXH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hash unit check failed");

`endif

/* hw/rtl/wmxh_pkg.sv */
// Package for the word multiply-xor hash unit: constants, mix result struct,
// and the 64-bit modular multiply. No dependencies.
package wmxh_pkg;

    localparam logic [63:0] SEED      = 64'd2166136261;
    localparam logic [63:0] FULL_MULT = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] TAIL_MULT = 64'hd6e8feb86659fd93;
    localparam logic [3:0]  WORD_BYTES = 4'd8;

    typedef struct packed {
        logic [63:0] acc;    // accumulator after this word
        logic [7:0]  len;    // length byte after this word
        logic        emit;   // word ends the key
        logic [31:0] hash;   // folded hash, meaningful when emit
    } t_mix_res;

    // Low 64 bits of a 64x64 product: only the low cross terms survive.
    function automatic logic [63:0] mul64_lo(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
        ll = {32'b0, a[31:0]} * {32'b0, b[31:0]};
        lh = a[31:0] * b[63:32];
        hl = a[63:32] * b[31:0];
        return ll + {lh + hl, 32'b0};
    endfunction

endpackage

/* hw/rtl/wmxh_mix.sv */
// Combinational mix step of the hash: one key word against the current state.
// Depends on wmxh_pkg.
module wmxh_mix (
    input  logic [63:0]        i_acc,
    input  logic [7:0]         i_len,
    input  logic [63:0]        i_data_word,
    input  logic [3:0]         i_valid_bytes,
    input  logic               i_last_word,
    output wmxh_pkg::t_mix_res o_res
);

    logic [3:0]  nb;
    logic        full;
    logic [7:0]  len_sum;
    logic [63:0] masked;
    logic [63:0] operand;
    logic [63:0] prod;
    logic [63:0] acc_new;

    // counts above eight act as a full word
    assign nb      = i_valid_bytes[3] ? wmxh_pkg::WORD_BYTES : i_valid_bytes;
    assign full    = (nb == wmxh_pkg::WORD_BYTES);
    assign len_sum = i_len + {4'b0, nb};

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            masked[8*i +: 8] = (4'(i) < nb) ? i_data_word[8*i +: 8] : 8'h00;
        end
    end

    // tail bytes move up one lane, length byte fills the bottom
    assign operand = i_acc ^ (full ? i_data_word : {masked[55:0], len_sum});
    assign prod    = wmxh_pkg::mul64_lo(operand,
                                        full ? wmxh_pkg::FULL_MULT : wmxh_pkg::TAIL_MULT);
    assign acc_new = (nb == 4'd0) ? i_acc : prod;

    assign o_res.acc  = acc_new;
    assign o_res.len  = len_sum;
    assign o_res.emit = !full || i_last_word;
    assign o_res.hash = acc_new[63:32] ^ acc_new[31:0];

endmodule

/* hw/rtl/word_multiply_xor_hash_unit.sv */
// Word multiply-xor hash unit: takes one 64-bit little-endian key word per
// cycle while o_in_stall is low and returns a folded 32-bit hash when the key
// ends (last_word set or fewer than eight bytes). Throughput is one word per
// clock unless a hash-producing word waits on a held output slot; a word is held
// in the input register and its hash is then loaded into the output register.
// The accumulator update (xor plus a 64-bit constant multiply, built from three
// 32-bit partial products) is combinational, which sets the one-word-per-clock rate.
// Depends on wmxh_pkg, wmxh_mix and word_multiply_xor_hash_unit_macros.svh.
`include "word_multiply_xor_hash_unit_macros.svh"

module word_multiply_xor_hash_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_valid_bytes,
    input  logic        i_last_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_value
);

    logic        r_in_valid;
    logic [63:0] r_word;
    logic [3:0]  r_nb;
    logic        r_last;
    logic [63:0] r_acc;
    logic [7:0]  r_len;
    logic        r_out_valid;
    logic [31:0] r_hash;

    wmxh_pkg::t_mix_res mix;
    logic               proceed;
    logic               in_take;

    wmxh_mix u_mix (
        .i_acc         (r_acc),
        .i_len         (r_len),
        .i_data_word   (r_word),
        .i_valid_bytes (r_nb),
        .i_last_word   (r_last),
        .o_res         (mix)
    );

    // a word only waits if it produces a hash and the output slot is still held
    assign proceed    = r_in_valid && (!mix.emit || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !proceed;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proceed) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_word <= i_data_word;
            r_nb   <= i_valid_bytes;
            r_last <= i_last_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= wmxh_pkg::SEED;
            r_len <= 8'd0;
        end else if (proceed) begin
            if (mix.emit) begin
                r_acc <= wmxh_pkg::SEED;
                r_len <= 8'd0;
            end else begin
                r_acc <= mix.acc;
                r_len <= mix.len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proceed && mix.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && mix.emit) begin
            r_hash <= mix.hash;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_hash;

    `WMXH_ASSERT_NOW(a_stall_needs_word, o_in_stall, r_in_valid)
    `WMXH_ASSERT_NOW(a_short_word_ends_key, r_in_valid && !r_nb[3], mix.emit)
    `WMXH_ASSERT_NEXT(a_emit_restarts, proceed && mix.emit,
        r_acc == wmxh_pkg::SEED && r_len == 8'd0)
    `WMXH_ASSERT_NEXT(a_emit_lands, proceed && mix.emit,
        r_out_valid && r_hash == $past(mix.hash))

endmodule

/* verif/tb.sv */
// Self-checking testbench for word_multiply_xor_hash_unit: a table of directed
// key words, then random keys, checked against a local multiply-xor predictor.
// Depends only on the RTL of the hash unit.
module tb;

    localparam logic [63:0] KEY_SEED  = 64'd2166136261;
    localparam logic [63:0] WORD_MULT = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] TAIL_MULT = 64'hd6e8feb86659fd93;
    localparam logic [31:0] SEED_HASH = 32'h811c9dc5;  // fold of the seed alone
    localparam int RANDOM_WORDS = 800;
    localparam int IDLE_LIMIT   = 500;
    localparam int N_ROWS       = 20;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        last;
        logic        known;   // hash typed in below
        logic [31:0] hash;
    } t_row;

    // Directed rows: empty keys, all-ones/all-zero words, every tail size,
    // oversized counts, garbage above the count, key closed by an empty word.
    t_row dir_rows [0:N_ROWS-1] = '{
        '{64'h0, 4'd0, 1'b0, 1'b1, SEED_HASH},
        '{64'hffffffffffffffff, 4'd0, 1'b1, 1'b1, SEED_HASH},
        '{64'h0, 4'd8, 1'b0, 1'b0, 32'h0},
        '{64'hffffffffffffffff, 4'd8, 1'b1, 1'b0, 32'h0},
        '{64'hffffffffffffffff, 4'd1, 1'b0, 1'b0, 32'h0},
        '{64'hffffffffffffffff, 4'd7, 1'b0, 1'b0, 32'h0},
        '{64'h0123456789abcdef, 4'd15, 1'b1, 1'b0, 32'h0},
        '{64'hfedcba9876543210, 4'd9, 1'b0, 1'b0, 32'h0},
        '{64'hdeadbeefcafef00d, 4'd3, 1'b1, 1'b0, 32'h0},
        '{64'h5555555555555555, 4'd8, 1'b0, 1'b0, 32'h0},
        '{64'haaaaaaaaaaaaaaaa, 4'd0, 1'b0, 1'b0, 32'h0},
        '{64'h0, 4'd8, 1'b1, 1'b0, 32'h0},
        '{64'hffffffffffffff12, 4'd1, 1'b1, 1'b0, 32'h0},
        '{64'hffffffffffff3412, 4'd2, 1'b0, 1'b0, 32'h0},
        '{64'hffffffffff563412, 4'd3, 1'b0, 1'b0, 32'h0},
        '{64'hffffffff78563412, 4'd4, 1'b1, 1'b0, 32'h0},
        '{64'hffffff9a78563412, 4'd5, 1'b0, 1'b0, 32'h0},
        '{64'hffffbc9a78563412, 4'd6, 1'b0, 1'b0, 32'h0},
        '{64'h7fffffffffffffff, 4'd8, 1'b0, 1'b0, 32'h0},
        '{64'h8000000000000000, 4'd7, 1'b0, 1'b0, 32'h0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [63:0] i_data_word;
    logic [3:0]  i_valid_bytes;
    logic        i_last_word;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_hash_value;

    word_multiply_xor_hash_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_word  (i_data_word),
        .i_valid_bytes(i_valid_bytes),
        .i_last_word  (i_last_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hash_value (o_hash_value)
    );

    // Predictor state
    logic [63:0] acc_model;
    logic [7:0]  len_model;
    logic [31:0] pending_hashes [$];

    int  err_cnt;
    int  words_sent;
    int  idle_cycles;
    int  stall_left;
    bit  calm;          // both sides run without idling while set
    bit  paused_once;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int draw_wait();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    // Advance the predictor by one word; returns 1 when the word ends the key.
    function automatic logic hash_step(input logic [63:0] w, input logic [3:0] vb,
                                       input logic lw, output logic [31:0] h);
        logic [3:0]  n;
        logic [63:0] mask;
        logic [63:0] tail;
        h = 32'h0;
        n = (vb > 4'd8) ? 4'd8 : vb;
        len_model = len_model + {4'd0, n};
        if (n == 4'd8) begin
            acc_model = (acc_model ^ w) * WORD_MULT;
            if (!lw)
                return 1'b0;
        end else if (n != 4'd0) begin
            mask = (64'd1 << (8 * n)) - 64'd1;
            tail = ((w & mask) << 8) | {56'd0, len_model};
            acc_model = (acc_model ^ tail) * TAIL_MULT;
        end
        h = acc_model[63:32] ^ acc_model[31:0];
        acc_model = KEY_SEED;
        len_model = 8'd0;
        return 1'b1;
    endfunction

    // Present one word, hold it until accepted, then log the expected hash when the word ends a key.
    task automatic send_word(input logic [63:0] w, input logic [3:0] vb, input logic lw,
                             input logic known, input logic [31:0] known_hash);
        int gap;
        logic [31:0] h;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_word   <= w;
        i_valid_bytes <= vb;
        i_last_word   <= lw;
        do @(posedge i_clk); while (o_in_stall);
        if (hash_step(w, vb, lw, h))
            pending_hashes.push_back(known ? known_hash : h);
        words_sent++;
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // One random key: full words (a few oversized counts, rare early ends),
    // then a tail word, an empty closing word, or last on the final full word.
    task automatic send_key();
        int nbytes;
        int full_words;
        int tail_bytes;
        int k;
        bit close_by_flag;
        logic [3:0] vb;
        logic lw;
        case ($urandom_range(0, 19))
            0:       nbytes = $urandom_range(200, 400);
            1, 2:    nbytes = $urandom_range(0, 7);
            default: nbytes = $urandom_range(1, 48);
        endcase
        full_words    = nbytes / 8;
        tail_bytes    = nbytes % 8;
        close_by_flag = $urandom_range(0, 1);
        for (k = 0; k < full_words; k++) begin
            vb = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
            lw = (k == full_words - 1) && tail_bytes == 0 && close_by_flag;
            if ($urandom_range(0, 29) == 0)
                lw = 1'b1;
            send_word(rand_word(), vb, lw, 1'b0, 32'h0);
        end
        if (tail_bytes != 0)
            send_word(rand_word(), 4'(tail_bytes), 1'($urandom_range(0, 1)), 1'b0, 32'h0);
        else if (!close_by_flag || full_words == 0)
            send_word(rand_word(), 4'd0, 1'($urandom_range(0, 1)), 1'b0, 32'h0);
    endtask

    // Output side: check each accepted hash, then draw the next stall stretch.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_hashes.size() == 0) begin
                    $error("hash_value with no word pending: actual %h", o_hash_value);
                    err_cnt++;
                end else begin
                    if (o_hash_value !== pending_hashes[0]) begin
                        $error("hash_value mismatch: expected %h, actual %h",
                               pending_hashes[0], o_hash_value);
                        err_cnt++;
                    end
                    void'(pending_hashes.pop_front());
                end
                stall_left = draw_wait();
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_out_stall <= (stall_left != 0);
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("word_multiply_xor_hash_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_data_word   = 64'h0;
        i_valid_bytes = 4'd0;
        i_last_word   = 1'b0;
        i_out_stall   = 1'b0;
        acc_model     = KEY_SEED;
        len_model     = 8'd0;
        err_cnt       = 0;
        words_sent    = 0;
        idle_cycles   = 0;
        stall_left    = 0;
        calm          = 1'b0;
        paused_once   = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++)
            send_word(dir_rows[r].data, dir_rows[r].nbytes, dir_rows[r].last,
                      dir_rows[r].known, dir_rows[r].hash);

        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 15) == 0)
                calm = ~calm;
            // drain everything once, midway, with the input side held off
            if (!paused_once && words_sent >= RANDOM_WORDS / 2) begin
                paused_once = 1'b1;
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending_hashes.size() != 0);
            end
            send_key();
        end

        i_in_valid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0)
            $display("word_multiply_xor_hash_unit test passed");
        else
            $display("word_multiply_xor_hash_unit test failed");
        $finish;
    end

endmodule

/* word_multiply_xor_hash_unit.f */
+incdir+hw/rtl
hw/rtl/wmxh_pkg.sv
hw/rtl/wmxh_mix.sv
hw/rtl/word_multiply_xor_hash_unit.sv
verif/tb.sv
